// ===== src/viewport_pan_zoom_transform_core_assert.svh =====
// Assertion macros for the viewport pan/zoom transform core
`ifndef VIEWPORT_PAN_ZOOM_TRANSFORM_CORE_ASSERT_SVH
`define VIEWPORT_PAN_ZOOM_TRANSFORM_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VPZ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vpz: same-cycle check failed");
`define VPZ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vpz: next-cycle check failed");
`else
`define VPZ_ASSERT_SAME(lbl, ante, cons)
`define VPZ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/vpz_pkg.sv =====
// Shared types, constants and helper functions for the viewport pan/zoom core
package vpz_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SIZE_W     = COORD_BITS - 1;
	localparam int ZOOM_W     = FRAC_BITS + 4;
	localparam int SCALE_W    = FRAC_BITS + 8;
	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int MID_W      = COORD_BITS + 1;

	localparam logic [ZOOM_W-1:0] ZOOM_ONE = ZOOM_W'(1) << FRAC_BITS;
	localparam logic [ZOOM_W-1:0] ZOOM_MIN = ZOOM_W'((1 << FRAC_BITS) / 10);
	localparam logic [ZOOM_W-1:0] ZOOM_MAX = ZOOM_W'(12 * (1 << FRAC_BITS));

	// shared unit widths
	localparam int A_W      = COORD_BITS + 2;
	localparam int MAG_W    = A_W;
	localparam int PROD_W   = MAG_W + SCALE_W;
	localparam int DIVD_W   = MAG_W + FRAC_BITS;
	// divisor never drops below ZOOM_MIN, so the top SKIP quotient bits are zero
	localparam int SKIP     = $clog2((1 << FRAC_BITS) / 10 + 1) - 1;
	localparam int QUO_W    = DIVD_W - SKIP;
	localparam int MULR_W   = PROD_W - FRAC_BITS;
	localparam int RMAG_W   = (MULR_W > QUO_W) ? MULR_W : QUO_W;
	localparam int RES_W    = RMAG_W + 1;
	localparam int ACC_W    = RES_W + 2;
	localparam int ITER_MAX = (QUO_W > SCALE_W) ? QUO_W : SCALE_W;
	localparam int CNT_W    = $clog2(ITER_MAX + 1);

	localparam logic [CMD_W-1:0] CMD_W2S  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_S2W  = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_PAN  = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_ZOOM = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_LOAD = CMD_W'(4);
	localparam logic [CMD_W-1:0] CMD_RECT = CMD_W'(5);

	localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = CFG_IDX_W'(3);

	localparam logic [2:0] STEP_LAST_ZOOM = 3'd4;
	localparam logic [2:0] STEP_LAST_STD  = 3'd1;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_sts_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_PREP,
		U_RUN,
		U_FIN
	} md_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ISSUE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [ACC_W-1:0] v
	);
		logic [ACC_W-COORD_BITS:0] top;
		logic signed [COORD_BITS-1:0] r;
		top = v[ACC_W-1:COORD_BITS-1];
		if (top == '0 || top == '1)
			r = v[COORD_BITS-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		return r;
	endfunction

	function automatic logic [ZOOM_W-1:0] clamp_zoom(input logic [RMAG_W-1:0] z);
		logic [ZOOM_W-1:0] r;
		if (z < RMAG_W'(ZOOM_MIN))
			r = ZOOM_MIN;
		else if (z > RMAG_W'(ZOOM_MAX))
			r = ZOOM_MAX;
		else
			r = z[ZOOM_W-1:0];
		return r;
	endfunction

endpackage

// ===== src/viewport_pan_zoom_transform_core.sv =====
// Top level of the viewport pan/zoom camera transform core
// Usage:
//   Requests enter on in_valid/in_stall with cmd, point_x, point_y and scale_value;
//   one result leaves per request on out_valid/out_stall. The viewport registers
//   are written on cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data;
//   write them only while no request is in flight, which the block does not enforce.
//   All multiplies and divides run through one shared unit that multiplies one
//   multiplier bit per cycle or divides one quotient bit per cycle, plus issue
//   and sign handling for each operation.
//   Work per request: load, rejected zoom and unused commands skip the unit;
//     world-to-screen takes two multiplies; screen-to-world, pan and visible
//     rect take two divides; zoom at anchor takes one multiply and four divides.
//   One request is in flight at a time; in_stall is high from accept until the
//   result is written to the output register. A result may wait in that register
//   under out_stall while the next request is accepted and computed; the block
//   then holds the finished request until the register frees up.
//   Reset clears the center to zero, the zoom to 1.0 and the viewport to zero.
`include "viewport_pan_zoom_transform_core_assert.svh"
module viewport_pan_zoom_transform_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [vpz_pkg::CMD_W-1:0]                 cmd,
	input  logic signed [vpz_pkg::COORD_BITS-1:0]     point_x,
	input  logic signed [vpz_pkg::COORD_BITS-1:0]     point_y,
	input  logic [vpz_pkg::SCALE_W-1:0]               scale_value,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [vpz_pkg::COORD_BITS-1:0]     out_x,
	output logic signed [vpz_pkg::COORD_BITS-1:0]     out_y,
	output logic [vpz_pkg::SIZE_W-1:0]                out_w,
	output logic [vpz_pkg::SIZE_W-1:0]                out_h,
	output logic [vpz_pkg::ZOOM_W-1:0]                zoom_now,
	output logic                                      rejected,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [vpz_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [vpz_pkg::COORD_BITS-1:0]            cfg_data
);
	import vpz_pkg::*;

	state_t state_q, state_d;
	logic [2:0] step_q;
	logic out_valid_q;

	logic signed [COORD_BITS-1:0] view_left_q, view_top_q;
	logic [SIZE_W-1:0] view_width_q, view_height_q;
	logic signed [COORD_BITS-1:0] center_x_q, center_y_q;
	logic [ZOOM_W-1:0] zoom_q;

	logic [CMD_W-1:0] cmd_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [SCALE_W-1:0] sv_q;
	logic signed [MID_W-1:0] mid_x_q, mid_y_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [ZOOM_W-1:0] nz_q;

	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [SIZE_W-1:0] out_w_q, out_h_q;
	logic [ZOOM_W-1:0] zoom_now_q;
	logic rejected_q;

	logic in_acc, skip_ops, last_step;
	logic ld_mid, issue, combine, out_load;

	md_req_t unit_req;
	md_sts_t unit_sts;
	logic signed [A_W-1:0] a_sel;
	logic [SCALE_W-1:0] b_sel;
	op_t op_sel;
	logic signed [RES_W-1:0] unit_res;

	logic signed [A_W-1:0] px_e, py_e, cx_e, cy_e, mx_e, my_e, vw_e, vh_e, z_e;
	logic [SCALE_W-1:0] zoom_b, nz_b;
	logic signed [ACC_W-1:0] r_acc, cx_acc, cy_acc, mx_acc, my_acc;

	logic upd_x, upd_y, upd_nz;
	logic signed [ACC_W-1:0] new_x, new_y;

	logic signed [COORD_BITS-1:0] fin_cx, fin_cy, fin_ox, fin_oy;
	logic [SIZE_W-1:0] fin_w, fin_h;
	logic [ZOOM_W-1:0] fin_zoom;
	logic fin_rej, fin_commit;

	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign skip_ops  = (cmd_q == CMD_LOAD) || (cmd_q > CMD_RECT)
		|| (cmd_q == CMD_ZOOM && sv_q == '0);
	assign last_step = (cmd_q == CMD_ZOOM) ? (step_q == STEP_LAST_ZOOM)
		: (step_q == STEP_LAST_STD);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_PREP;
			ST_PREP:   state_d = skip_ops ? ST_FINISH : ST_ISSUE;
			ST_ISSUE:  state_d = ST_WAIT;
			ST_WAIT:   if (unit_sts.done) state_d = last_step ? ST_FINISH : ST_ISSUE;
			ST_FINISH: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = 1'b1;
		ld_mid   = 1'b0;
		issue    = 1'b0;
		combine  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_PREP:   ld_mid = 1'b1;
			ST_ISSUE:  issue = 1'b1;
			ST_WAIT:   combine = unit_sts.done;
			ST_FINISH: out_load = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	always_comb begin
		px_e   = {{2{px_q[COORD_BITS-1]}}, px_q};
		py_e   = {{2{py_q[COORD_BITS-1]}}, py_q};
		cx_e   = {{2{center_x_q[COORD_BITS-1]}}, center_x_q};
		cy_e   = {{2{center_y_q[COORD_BITS-1]}}, center_y_q};
		mx_e   = {mid_x_q[MID_W-1], mid_x_q};
		my_e   = {mid_y_q[MID_W-1], mid_y_q};
		vw_e   = {3'b000, view_width_q};
		vh_e   = {3'b000, view_height_q};
		z_e    = {{(A_W-ZOOM_W){1'b0}}, zoom_q};
		zoom_b = {{(SCALE_W-ZOOM_W){1'b0}}, zoom_q};
		nz_b   = {{(SCALE_W-ZOOM_W){1'b0}}, nz_q};
	end

	// operand select for the shared unit
	always_comb begin
		a_sel  = '0;
		b_sel  = zoom_b;
		op_sel = OP_DIV;
		unique case (cmd_q)
			CMD_W2S: begin
				op_sel = OP_MUL;
				a_sel  = (step_q == 3'd0) ? (px_e - cx_e) : (py_e - cy_e);
			end
			CMD_S2W: a_sel = (step_q == 3'd0) ? (px_e - mx_e) : (py_e - my_e);
			CMD_PAN: a_sel = (step_q == 3'd0) ? px_e : py_e;
			CMD_ZOOM: begin
				unique case (step_q)
					3'd0: begin
						op_sel = OP_MUL;
						a_sel  = z_e;
						b_sel  = sv_q;
					end
					3'd1: a_sel = px_e - mx_e;
					3'd2: begin
						a_sel = px_e - mx_e;
						b_sel = nz_b;
					end
					3'd3: begin
						a_sel = py_e - my_e;
						b_sel = nz_b;
					end
					default: a_sel = py_e - my_e;
				endcase
			end
			CMD_RECT: a_sel = (step_q == 3'd0) ? vw_e : vh_e;
			default: a_sel = '0;
		endcase
	end

	assign unit_req.start = issue;
	assign unit_req.op    = op_sel;

	vpz_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.a      (a_sel),
		.b      (b_sel),
		.sts    (unit_sts),
		.res    (unit_res)
	);

	// fold each unit result into the accumulators
	always_comb begin
		r_acc  = {{(ACC_W-RES_W){unit_res[RES_W-1]}}, unit_res};
		cx_acc = {{(ACC_W-COORD_BITS){center_x_q[COORD_BITS-1]}}, center_x_q};
		cy_acc = {{(ACC_W-COORD_BITS){center_y_q[COORD_BITS-1]}}, center_y_q};
		mx_acc = {{(ACC_W-MID_W){mid_x_q[MID_W-1]}}, mid_x_q};
		my_acc = {{(ACC_W-MID_W){mid_y_q[MID_W-1]}}, mid_y_q};
		upd_x  = 1'b0;
		upd_y  = 1'b0;
		upd_nz = 1'b0;
		new_x  = acc_x_q;
		new_y  = acc_y_q;
		unique case (cmd_q)
			CMD_W2S: begin
				upd_x = (step_q == 3'd0);
				upd_y = (step_q != 3'd0);
				new_x = mx_acc + r_acc;
				new_y = my_acc - r_acc;
			end
			CMD_S2W: begin
				upd_x = (step_q == 3'd0);
				upd_y = (step_q != 3'd0);
				new_x = cx_acc + r_acc;
				new_y = cy_acc - r_acc;
			end
			CMD_PAN: begin
				upd_x = (step_q == 3'd0);
				upd_y = (step_q != 3'd0);
				new_x = cx_acc - r_acc;
				new_y = cy_acc + r_acc;
			end
			CMD_ZOOM: begin
				unique case (step_q)
					3'd0: upd_nz = 1'b1;
					3'd1: begin
						upd_x = 1'b1;
						new_x = cx_acc + r_acc;
					end
					3'd2: begin
						upd_x = 1'b1;
						new_x = acc_x_q - r_acc;
					end
					3'd3: begin
						upd_y = 1'b1;
						new_y = cy_acc + r_acc;
					end
					default: begin
						upd_y = 1'b1;
						new_y = acc_y_q - r_acc;
					end
				endcase
			end
			CMD_RECT: begin
				upd_x = (step_q == 3'd0);
				upd_y = (step_q != 3'd0);
				new_x = r_acc;
				new_y = r_acc;
			end
			default: upd_x = 1'b0;
		endcase
	end

	// final values for outputs and state
	always_comb begin
		fin_cx     = center_x_q;
		fin_cy     = center_y_q;
		fin_zoom   = zoom_q;
		fin_ox     = '0;
		fin_oy     = '0;
		fin_w      = '0;
		fin_h      = '0;
		fin_rej    = 1'b0;
		fin_commit = 1'b0;
		unique case (cmd_q)
			CMD_W2S, CMD_S2W: begin
				fin_ox = sat_coord(acc_x_q);
				fin_oy = sat_coord(acc_y_q);
			end
			CMD_PAN: begin
				fin_commit = 1'b1;
				fin_cx     = sat_coord(acc_x_q);
				fin_cy     = sat_coord(acc_y_q);
				fin_ox     = fin_cx;
				fin_oy     = fin_cy;
			end
			CMD_ZOOM: begin
				if (sv_q == '0) begin
					fin_rej = 1'b1;
				end else begin
					fin_commit = 1'b1;
					fin_cx     = sat_coord(acc_x_q);
					fin_cy     = sat_coord(acc_y_q);
					fin_zoom   = nz_q;
				end
				fin_ox = fin_cx;
				fin_oy = fin_cy;
			end
			CMD_LOAD: begin
				fin_commit = 1'b1;
				fin_cx     = px_q;
				fin_cy     = py_q;
				fin_zoom   = clamp_zoom(RMAG_W'(sv_q));
				fin_ox     = px_q;
				fin_oy     = py_q;
			end
			CMD_RECT: begin
				fin_ox = sat_coord(cx_acc - (acc_x_q >>> 1));
				fin_oy = sat_coord(cy_acc - (acc_y_q >>> 1));
				fin_w  = (|acc_x_q[ACC_W-1:SIZE_W]) ? '1 : acc_x_q[SIZE_W-1:0];
				fin_h  = (|acc_y_q[ACC_W-1:SIZE_W]) ? '1 : acc_y_q[SIZE_W-1:0];
			end
			default: fin_commit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			view_left_q   <= '0;
			view_top_q    <= '0;
			view_width_q  <= '0;
			view_height_q <= '0;
			center_x_q    <= '0;
			center_y_q    <= '0;
			zoom_q        <= ZOOM_ONE;
		end else begin
			state_q <= state_d;
			if (in_acc)
				step_q <= '0;
			else if (combine && !last_step)
				step_q <= step_q + 3'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_VIEW_LEFT:   view_left_q   <= cfg_data;
					REG_VIEW_TOP:    view_top_q    <= cfg_data;
					REG_VIEW_WIDTH:  view_width_q  <= cfg_data[SIZE_W-1:0];
					REG_VIEW_HEIGHT: view_height_q <= cfg_data[SIZE_W-1:0];
				endcase
			end
			if (out_load && fin_commit) begin
				center_x_q <= fin_cx;
				center_y_q <= fin_cy;
				zoom_q     <= fin_zoom;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd;
			px_q  <= point_x;
			py_q  <= point_y;
			sv_q  <= scale_value;
		end
		if (ld_mid) begin
			mid_x_q <= {view_left_q[COORD_BITS-1], view_left_q}
				+ {3'b000, view_width_q[SIZE_W-1:1]};
			mid_y_q <= {view_top_q[COORD_BITS-1], view_top_q}
				+ {3'b000, view_height_q[SIZE_W-1:1]};
		end
		if (combine) begin
			if (upd_x)
				acc_x_q <= new_x;
			if (upd_y)
				acc_y_q <= new_y;
			if (upd_nz)
				nz_q <= clamp_zoom(unit_res[RMAG_W-1:0]);
		end
		if (out_load) begin
			out_x_q    <= fin_ox;
			out_y_q    <= fin_oy;
			out_w_q    <= fin_w;
			out_h_q    <= fin_h;
			zoom_now_q <= fin_zoom;
			rejected_q <= fin_rej;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_w     = out_w_q;
	assign out_h     = out_h_q;
	assign zoom_now  = zoom_now_q;
	assign rejected  = rejected_q;

	`VPZ_ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall)
	`VPZ_ASSERT_SAME(a_zoom_in_range, 1'b1, zoom_q >= ZOOM_MIN && zoom_q <= ZOOM_MAX)
	`VPZ_ASSERT_SAME(a_unit_alive, state_q == ST_WAIT, unit_sts.busy || unit_sts.done)
	`VPZ_ASSERT_SAME(a_done_only_waiting, unit_sts.done, state_q == ST_WAIT)

endmodule

// ===== src/vpz_muldiv.sv =====
// Shared bit-serial multiply / restoring divide unit with sign-magnitude handling
module vpz_muldiv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vpz_pkg::md_req_t                    req,
	input  logic signed [vpz_pkg::A_W-1:0]      a,
	input  logic [vpz_pkg::SCALE_W-1:0]         b,
	output vpz_pkg::md_sts_t                    sts,
	output logic signed [vpz_pkg::RES_W-1:0]    res
);
	import vpz_pkg::*;

	md_phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;

	op_t op_q;
	logic neg_q;
	logic signed [A_W-1:0] a_q;
	logic [SCALE_W-1:0] b_q;
	logic [MAG_W-1:0] mag_q;
	logic [PROD_W-1:0] prod_q;
	logic [SCALE_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic signed [RES_W-1:0] res_q;

	logic ld_op, ld_init, do_iter, ld_res;
	logic [MAG_W-1:0] mag_d;
	logic [DIVD_W-1:0] dividend;
	logic [SCALE_W:0] trial;
	logic [SCALE_W:0] trial_sub;
	logic fits;
	logic [RMAG_W-1:0] rmag;
	logic signed [RES_W-1:0] rpos;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			U_IDLE: if (req.start) phase_d = U_PREP;
			U_PREP: phase_d = U_RUN;
			U_RUN:  if (cnt_q == CNT_W'(1)) phase_d = U_FIN;
			U_FIN:  phase_d = U_IDLE;
		endcase
	end

	always_comb begin
		ld_op   = 1'b0;
		ld_init = 1'b0;
		do_iter = 1'b0;
		ld_res  = 1'b0;
		unique case (phase_q)
			U_IDLE: ld_op = req.start;
			U_PREP: ld_init = 1'b1;
			U_RUN:  do_iter = 1'b1;
			U_FIN:  ld_res = 1'b1;
		endcase
	end

	always_comb begin
		mag_d     = a_q[A_W-1] ? (MAG_W'(~a_q) + MAG_W'(1)) : MAG_W'(a_q);
		dividend  = {mag_d, {FRAC_BITS{1'b0}}};
		trial     = {rem_q, quo_q[QUO_W-1]};
		fits      = trial >= {1'b0, b_q};
		trial_sub = trial - {1'b0, b_q};
		if (op_q == OP_MUL)
			rmag = RMAG_W'(prod_q[PROD_W-1:FRAC_BITS]);
		else
			rmag = RMAG_W'(quo_q);
		rpos = $signed({1'b0, rmag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= ld_res;
			if (ld_init)
				cnt_q <= (op_q == OP_MUL) ? CNT_W'(SCALE_W) : CNT_W'(QUO_W);
			else if (do_iter)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_op) begin
			op_q  <= req.op;
			neg_q <= a[A_W-1];
			a_q   <= a;
			b_q   <= b;
		end
		if (ld_init) begin
			mag_q  <= mag_d;
			prod_q <= '0;
			rem_q  <= SCALE_W'(dividend[DIVD_W-1 -: SKIP]);
			quo_q  <= dividend[QUO_W-1:0];
		end
		if (do_iter) begin
			if (op_q == OP_MUL) begin
				// MSB-first shift-add over the multiplier bits
				prod_q <= {prod_q[PROD_W-2:0], 1'b0}
					+ (b_q[SCALE_W-1] ? PROD_W'(mag_q) : PROD_W'(0));
				b_q    <= {b_q[SCALE_W-2:0], 1'b0};
			end else begin
				rem_q <= fits ? trial_sub[SCALE_W-1:0] : trial[SCALE_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], fits};
			end
		end
		if (ld_res)
			res_q <= neg_q ? -rpos : rpos;
	end

	assign sts.busy = (phase_q != U_IDLE);
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

// ===== sim/viewport_pan_zoom_transform_core_test.sv =====
// Self-checking testbench for the viewport pan/zoom camera transform core
`timescale 1ns / 100ps

module viewport_pan_zoom_transform_core_test;
	import vpz_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam longint WIDE_LIM = longint'(1) << 61;
	localparam longint COORD_HI = (longint'(1) << (CB - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam longint unsigned Z_ONE = 64'd1 << FB;
	localparam longint unsigned Z_MIN = Z_ONE / 10;
	localparam longint unsigned Z_MAX = Z_ONE * 12;
	localparam longint unsigned FRAC_MASK = Z_ONE - 1;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 250;

	localparam logic [CMD_W-1:0] CMD_SPARE6 = CMD_W'(6);
	localparam logic [CMD_W-1:0] CMD_SPARE7 = CMD_W'(7);
	localparam logic [CMD_W-1:0] CMD_LIST [6] =
		'{CMD_W2S, CMD_S2W, CMD_PAN, CMD_ZOOM, CMD_LOAD, CMD_RECT};
	localparam logic [CFG_IDX_W-1:0] REG_LIST [4] =
		'{REG_VIEW_LEFT, REG_VIEW_TOP, REG_VIEW_WIDTH, REG_VIEW_HEIGHT};

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic [SIZE_W-1:0]    w;
		logic [SIZE_W-1:0]    h;
		logic [ZOOM_W-1:0]    zoom;
		logic                 rej;
	} view_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [CMD_W-1:0]        cmd;
	logic signed [CB-1:0]    point_x;
	logic signed [CB-1:0]    point_y;
	logic [SCALE_W-1:0]      scale_value;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [CB-1:0]    out_x;
	logic signed [CB-1:0]    out_y;
	logic [SIZE_W-1:0]       out_w;
	logic [SIZE_W-1:0]       out_h;
	logic [ZOOM_W-1:0]       zoom_now;
	logic                    rejected;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CB-1:0]           cfg_data;

	// camera state as the block should hold it
	longint          cam_cx;
	longint          cam_cy;
	longint unsigned cam_zoom;
	longint          vp_left;
	longint          vp_top;
	longint          vp_w;
	longint          vp_h;

	view_result_t pending_views [$];
	view_result_t want;
	int  errors;
	bit  feeding;
	bit  feed_gaps;
	bit  drain_stalls;
	int  hold_requests;

	viewport_pan_zoom_transform_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.point_x     (point_x),
		.point_y     (point_y),
		.scale_value (scale_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_w       (out_w),
		.out_h       (out_h),
		.zoom_now    (zoom_now),
		.rejected    (rejected),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat_q16(input longint v);
		return (v > COORD_HI) ? COORD_HI : (v < COORD_LO) ? COORD_LO : v;
	endfunction

	function automatic longint unsigned limit_zoom(input longint unsigned z);
		return (z < Z_MIN) ? Z_MIN : (z > Z_MAX) ? Z_MAX : z;
	endfunction

	// (a * z) >> FB on the magnitude, truncating toward zero
	function automatic longint zoom_mul(input longint a, input longint unsigned z);
		longint v;
		longint unsigned mag, hi, lo, res;
		bit neg;
		neg = (a < 0);
		v = (a > WIDE_LIM) ? WIDE_LIM : (a < -WIDE_LIM) ? -WIDE_LIM : a;
		mag = neg ? -v : v;
		hi = mag >> FB;
		lo = mag & FRAC_MASK;
		if (z != 0 && hi > WIDE_LIM / z)
			res = WIDE_LIM;
		else
			res = hi * z + ((lo * z) >> FB);
		if (res > WIDE_LIM)
			res = WIDE_LIM;
		return neg ? -longint'(res) : longint'(res);
	endfunction

	// (a << FB) / z on the magnitude, truncating toward zero
	function automatic longint zoom_div(input longint a, input longint unsigned z);
		longint v;
		longint unsigned mag, q, r, res;
		bit neg;
		if (z == 0)
			return 0;
		neg = (a < 0);
		v = (a > WIDE_LIM) ? WIDE_LIM : (a < -WIDE_LIM) ? -WIDE_LIM : a;
		mag = neg ? -v : v;
		q = mag / z;
		r = mag % z;
		if (q > (WIDE_LIM >> FB))
			res = WIDE_LIM;
		else
			res = (q << FB) + ((r << FB) / z);
		if (res > WIDE_LIM)
			res = WIDE_LIM;
		return neg ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint view_mid_x();
		return vp_left + (vp_w >>> 1);
	endfunction

	function automatic longint view_mid_y();
		return vp_top + (vp_h >>> 1);
	endfunction

	function automatic void camera_reset();
		cam_cx = 0;
		cam_cy = 0;
		cam_zoom = Z_ONE;
		vp_left = 0;
		vp_top = 0;
		vp_w = 0;
		vp_h = 0;
	endfunction

	function automatic void apply_view_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CB-1:0] d);
		case (idx)
			REG_VIEW_LEFT:   vp_left = longint'($signed(d));
			REG_VIEW_TOP:    vp_top = longint'($signed(d));
			REG_VIEW_WIDTH:  vp_w = longint'(d[CB-2:0]);
			REG_VIEW_HEIGHT: vp_h = longint'(d[CB-2:0]);
			default: ;
		endcase
	endfunction

	function automatic view_result_t camera_step(input logic [CMD_W-1:0] c,
		input logic signed [CB-1:0] px_in, input logic signed [CB-1:0] py_in,
		input logic [SCALE_W-1:0] sv_in);
		view_result_t r;
		longint px, py, ox, oy, ow, oh, dx, dy, sx, sy;
		longint unsigned sv, nz;
		logic rej;
		px = px_in;
		py = py_in;
		sv = sv_in;
		ox = 0;
		oy = 0;
		ow = 0;
		oh = 0;
		rej = 1'b0;
		case (c)
			CMD_W2S: begin
				ox = sat_q16(view_mid_x() + zoom_mul(px - cam_cx, cam_zoom));
				oy = sat_q16(view_mid_y() - zoom_mul(py - cam_cy, cam_zoom));
			end
			CMD_S2W: begin
				ox = sat_q16(cam_cx + zoom_div(px - view_mid_x(), cam_zoom));
				oy = sat_q16(cam_cy - zoom_div(py - view_mid_y(), cam_zoom));
			end
			CMD_PAN: begin
				cam_cx = sat_q16(cam_cx - zoom_div(px, cam_zoom));
				cam_cy = sat_q16(cam_cy + zoom_div(py, cam_zoom));
				ox = cam_cx;
				oy = cam_cy;
			end
			CMD_ZOOM: begin
				if (sv == 0) begin
					rej = 1'b1;
				end else begin
					// keep the world point under the anchor fixed
					nz = limit_zoom((cam_zoom * sv) >> FB);
					dx = px - view_mid_x();
					dy = py - view_mid_y();
					sx = zoom_div(dx, cam_zoom) - zoom_div(dx, nz);
					sy = zoom_div(dy, nz) - zoom_div(dy, cam_zoom);
					cam_zoom = nz;
					cam_cx = sat_q16(cam_cx + sx);
					cam_cy = sat_q16(cam_cy + sy);
				end
				ox = cam_cx;
				oy = cam_cy;
			end
			CMD_LOAD: begin
				cam_cx = px;
				cam_cy = py;
				cam_zoom = limit_zoom(sv);
				ox = cam_cx;
				oy = cam_cy;
			end
			CMD_RECT: begin
				ow = zoom_div(vp_w, cam_zoom);
				oh = zoom_div(vp_h, cam_zoom);
				ox = sat_q16(cam_cx - (ow >>> 1));
				oy = sat_q16(cam_cy - (oh >>> 1));
				if (ow > COORD_HI)
					ow = COORD_HI;
				if (oh > COORD_HI)
					oh = COORD_HI;
			end
			default: ;
		endcase
		r.x = CB'(ox);
		r.y = CB'(oy);
		r.w = SIZE_W'(ow);
		r.h = SIZE_W'(oh);
		r.zoom = ZOOM_W'(cam_zoom);
		r.rej = rej;
		return r;
	endfunction

	function automatic logic signed [CB-1:0] q16(input int v);
		return CB'(v) << FB;
	endfunction

	function automatic longint spread(input int unsigned span);
		return longint'($urandom_range(0, 2 * span)) - longint'(span);
	endfunction

	task automatic report_mismatch(input string field, input longint exp_v,
		input longint got_v);
		errors++;
		$error("%s expected %0d got %0d", field, exp_v, got_v);
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				report_mismatch("unexpected out_x", 0, out_x);
			end else begin
				want = pending_views.pop_front();
				if (out_x !== want.x)
					report_mismatch("out_x", want.x, out_x);
				if (out_y !== want.y)
					report_mismatch("out_y", want.y, out_y);
				if (out_w !== want.w)
					report_mismatch("out_w", want.w, out_w);
				if (out_h !== want.h)
					report_mismatch("out_h", want.h, out_h);
				if (zoom_now !== want.zoom)
					report_mismatch("zoom_now", want.zoom, zoom_now);
				if (rejected !== want.rej)
					report_mismatch("rejected", want.rej, rejected);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= drain_stalls && ($urandom_range(0, 99) < 28);
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] c, input logic signed [CB-1:0] px,
		input logic signed [CB-1:0] py, input logic [SCALE_W-1:0] sv);
		int gap;
		gap = 0;
		if (feed_gaps && $urandom_range(0, 99) < 28)
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8);
		if (gap > 0) begin
			if (feeding)
				in_valid <= 1'b0;
			feeding = 1'b0;
			repeat (gap) @(posedge clk);
		end
		// hold valid high across back-to-back requests
		in_valid <= 1'b1;
		feeding = 1'b1;
		cmd <= c;
		point_x <= px;
		point_y <= py;
		scale_value <= sv;
		do @(posedge clk); while (in_stall);
		pending_views.push_back(camera_step(c, px, py, sv));
	endtask

	task automatic wait_drained();
		if (feeding)
			in_valid <= 1'b0;
		feeding = 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic set_viewport(input logic [CB-1:0] left, input logic [CB-1:0] top,
		input logic [CB-1:0] width, input logic [CB-1:0] height);
		logic [CB-1:0] vals [4];
		vals = '{left, top, width, height};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_LIST[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			apply_view_reg(REG_LIST[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly plausible camera traffic, some full-range noise
	task automatic send_random_request();
		logic [CMD_W-1:0] c;
		logic signed [CB-1:0] px, py;
		logic [SCALE_W-1:0] sv;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 4)
			c = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
		else
			c = CMD_LIST[$urandom_range(0, 5)];
		px = $urandom;
		py = $urandom;
		sv = SCALE_W'($urandom);
		if (roll >= 20) begin
			case (c)
				CMD_W2S: begin
					px = CB'(cam_cx + spread(1 << 22));
					py = CB'(cam_cy + spread(1 << 22));
				end
				CMD_S2W, CMD_ZOOM: begin
					px = CB'(view_mid_x() + spread(1 << 24));
					py = CB'(view_mid_y() + spread(1 << 24));
				end
				CMD_PAN: begin
					px = CB'(spread(1 << 22));
					py = CB'(spread(1 << 22));
				end
				CMD_LOAD: begin
					px = CB'(spread(1 << 26));
					py = CB'(spread(1 << 26));
					sv = SCALE_W'($urandom_range(32'(Z_MIN) - 64, 32'(Z_MAX) + 64));
				end
				default: ;
			endcase
			if (c == CMD_ZOOM) begin
				if (roll < 26)
					sv = '0;
				else if (roll < 34)
					sv = SCALE_W'($urandom_range(1, 64));
				else
					sv = SCALE_W'($urandom_range(32'(Z_ONE >> 1), 32'(Z_ONE << 1)));
			end
		end
		send_request(c, px, py, sv);
	endtask

	task automatic test_directed_cases();
		// one request on the reset viewport first
		send_request(CMD_W2S, '0, '0, '0);
		set_viewport(q16(0), q16(0), q16(800), q16(600));
		send_request(CMD_W2S, q16(10), q16(-20), '0);
		send_request(CMD_S2W, q16(100), q16(50), '0);
		send_request(CMD_PAN, q16(8), q16(-4), '0);
		send_request(CMD_ZOOM, q16(400), q16(300), SCALE_W'(Z_ONE << 1));
		// zero factor is rejected
		send_request(CMD_ZOOM, q16(10), q16(10), '0);
		send_request(CMD_ZOOM, q16(700), q16(20), '1);
		send_request(CMD_S2W, q16(-300), q16(900), '0);
		send_request(CMD_ZOOM, q16(0), q16(600), SCALE_W'(1));
		send_request(CMD_RECT, '0, '0, '0);
		// load with out-of-range zoom clamps
		send_request(CMD_LOAD, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, '0);
		send_request(CMD_W2S, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, '0);
		send_request(CMD_PAN, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, '0);
		send_request(CMD_LOAD, '0, '0, '1);
		send_request(CMD_RECT, '0, '0, '1);
		send_request(CMD_SPARE6, '1, '1, '1);
		send_request(CMD_SPARE7, '1, '0, '1);
		send_request(CMD_LOAD, '0, '0, SCALE_W'(Z_ONE));
		set_viewport({1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, '1, '1);
		send_request(CMD_LOAD, '0, '0, SCALE_W'(Z_MIN));
		send_request(CMD_RECT, '0, '0, '0);
		send_request(CMD_S2W, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, '0);
		send_request(CMD_ZOOM, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}},
			SCALE_W'(Z_ONE >> 1));
		send_request(CMD_W2S, '1, '1, '0);
		wait_drained();
	endtask

	task automatic test_viewport_extremes();
		logic [CB-1:0] lefts [3], tops [3], widths [3], heights [3];
		lefts = '{{1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, '0};
		tops = '{{1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, '0};
		widths = '{'1, '0, CB'(1)};
		heights = '{'0, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-2){1'b0}}, 1'b1}};
		for (int s = 0; s < 3; s++) begin
			set_viewport(lefts[s], tops[s], widths[s], heights[s]);
			repeat (60) send_random_request();
		end
		wait_drained();
	endtask

	task automatic test_random_sessions();
		logic [CB-1:0] left, top, width, height;
		for (int s = 0; s < 10; s++) begin
			left = ($urandom_range(0, 9) == 0) ? $urandom : CB'(spread(1 << 26));
			top = ($urandom_range(0, 9) == 0) ? $urandom : CB'(spread(1 << 26));
			width = ($urandom_range(0, 9) == 0) ? $urandom
				: CB'($urandom_range(0, 32'd4000 << FB));
			height = ($urandom_range(0, 9) == 0) ? $urandom
				: CB'($urandom_range(0, 32'd4000 << FB));
			width[CB-1] = $urandom_range(0, 1);
			height[CB-1] = $urandom_range(0, 1);
			set_viewport(left, top, width, height);
			repeat (120) send_random_request();
		end
		wait_drained();
	endtask

	task automatic test_output_holdoff();
		// keep offering requests while the receiver holds off
		feed_gaps = 1'b0;
		hold_requests++;
		repeat (10) send_random_request();
		wait_drained();
		feed_gaps = 1'b1;
		repeat (10) send_random_request();
		wait_drained();
	endtask

	task automatic test_steady_stream();
		feed_gaps = 1'b0;
		drain_stalls = 1'b0;
		repeat (350) send_random_request();
		wait_drained();
		feed_gaps = 1'b1;
		drain_stalls = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_W2S;
		point_x = '0;
		point_y = '0;
		scale_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VIEW_LEFT;
		cfg_data = '0;
		errors = 0;
		feeding = 1'b0;
		feed_gaps = 1'b1;
		drain_stalls = 1'b1;
		hold_requests = 0;
		camera_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_viewport_extremes();
		test_output_holdoff();
		test_random_sessions();
		test_steady_stream();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_views.size() == 0)
			$display("[viewport_pan_zoom_transform_core] OK");
		else
			$display("[viewport_pan_zoom_transform_core] ERROR");
		$finish;
	end

	initial begin
		#30ms;
		$display("[viewport_pan_zoom_transform_core] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/vpz_pkg.sv
src/vpz_muldiv.sv
src/viewport_pan_zoom_transform_core.sv
sim/viewport_pan_zoom_transform_core_test.sv
